// ===== rtl/acr_pkg.sv =====
// Shared definitions for the AES cipher round pipeline.
// Holds the S-box table, the GF(2^8) doubling function and the control struct.
// No dependencies.
`timescale 1ns / 1ps

package acr_pkg;

	typedef struct packed {
		logic valid;
		logic final_round;
	} acr_ctrl_t;

	localparam logic [7:0] SBOX_TAB [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] GF_POLY = 8'h1b;

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		gf_double = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

endpackage

// ===== rtl/acr_sub_shift.sv =====
// SubBytes and ShiftRows stage of the AES cipher round.
// Depends on acr_pkg for the S-box table and control struct.
`timescale 1ns / 1ps

module acr_sub_shift (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [127:0]       state_s1,
	input  logic [127:0]       key_s1,
	input  acr_pkg::acr_ctrl_t ctrl_s1,
	output logic [127:0]       sh_s2,
	output logic [127:0]       key_s2,
	output acr_pkg::acr_ctrl_t ctrl_s2
);

	logic [127:0] sh_d;

	for (genvar c = 0; c < 4; c++) begin : g_col
		for (genvar r = 0; r < 4; r++) begin : g_row
			localparam int unsigned DST = r + 4 * c;
			localparam int unsigned SRC = r + 4 * ((c + r) % 4);
			assign sh_d[127 - 8 * DST -: 8] = acr_pkg::SBOX_TAB[state_s1[127 - 8 * SRC -: 8]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sh_s2  <= sh_d;
		key_s2 <= key_s1;
	end

endmodule

// ===== rtl/acr_mix_key.sv =====
// MixColumns and AddRoundKey stage of the AES cipher round.
// Depends on acr_pkg for gf_double and the control struct.
`timescale 1ns / 1ps

module acr_mix_key (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [127:0]       sh_s2,
	input  logic [127:0]       key_s2,
	input  acr_pkg::acr_ctrl_t ctrl_s2,
	output logic [127:0]       result_s3,
	output logic               valid_s3
);

	logic [127:0] mix;

	for (genvar c = 0; c < 4; c++) begin : g_col
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		assign a0 = sh_s2[127 - 32 * c -: 8];
		assign a1 = sh_s2[119 - 32 * c -: 8];
		assign a2 = sh_s2[111 - 32 * c -: 8];
		assign a3 = sh_s2[103 - 32 * c -: 8];
		assign d0 = acr_pkg::gf_double(a0);
		assign d1 = acr_pkg::gf_double(a1);
		assign d2 = acr_pkg::gf_double(a2);
		assign d3 = acr_pkg::gf_double(a3);
		assign mix[127 - 32 * c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
		assign mix[119 - 32 * c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
		assign mix[111 - 32 * c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
		assign mix[103 - 32 * c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_s3 <= (ctrl_s2.final_round ? sh_s2 : mix) ^ key_s2;
	end

endmodule

// ===== rtl/aes_cipher_round.sv =====
// Top level of the AES cipher round pipeline.
// Depends on acr_pkg, acr_sub_shift and acr_mix_key.
//
// Channel   Handshake          Payload
// input     start, busy        state_hi, state_lo, key_hi, key_lo, final_round
// result    done (strobe)      result_hi, result_lo
//
// Three register stages: input capture, SubBytes/ShiftRows, MixColumns/AddRoundKey.
// One item enters every cycle; done is registered with the result in the
// MixColumns/AddRoundKey stage, and the result is taken while done is high.
// busy stays low: the pipeline always advances, as the receiver cannot stall.
// Reset clears the control bits only; payload registers hold whatever they held.
`timescale 1ns / 1ps

module aes_cipher_round (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] state_hi,
	input  logic [63:0] state_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	input  logic        final_round,
	output logic        done,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	logic [127:0]       state_s1;
	logic [127:0]       key_s1;
	acr_pkg::acr_ctrl_t ctrl_s1;
	logic [127:0]       sh_s2;
	logic [127:0]       key_s2;
	acr_pkg::acr_ctrl_t ctrl_s2;
	logic [127:0]       result_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid       <= start && !busy;
			ctrl_s1.final_round <= final_round;
		end
	end

	always_ff @(posedge clk) begin
		state_s1 <= {state_hi, state_lo};
		key_s1   <= {key_hi, key_lo};
	end

	acr_sub_shift u_sub_shift (
		.clk      (clk),
		.arst_n   (arst_n),
		.state_s1 (state_s1),
		.key_s1   (key_s1),
		.ctrl_s1  (ctrl_s1),
		.sh_s2    (sh_s2),
		.key_s2   (key_s2),
		.ctrl_s2  (ctrl_s2)
	);

	acr_mix_key u_mix_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.sh_s2     (sh_s2),
		.key_s2    (key_s2),
		.ctrl_s2   (ctrl_s2),
		.result_s3 (result_s3),
		.valid_s3  (done)
	);

	assign result_hi = result_s3[127:64];
	assign result_lo = result_s3[63:0];

endmodule

// ===== bench/aes_cipher_round_tb.sv =====
// Self-checking bench for aes_cipher_round: directed and random rounds, each checked
// against a bit-exact round model built into this file.
// Depends on acr_pkg (S-box table, reduction polynomial) and the aes_cipher_round RTL.
`timescale 1ns / 1ps

module aes_cipher_round_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_ROUNDS = 1100;

	typedef struct {
		logic [63:0] st_hi;
		logic [63:0] st_lo;
		logic [63:0] rk_hi;
		logic [63:0] rk_lo;
		logic        last;
		int          gap_after;
		bit          drain_first;
	} round_item_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} round_out_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] state_hi = '0;
	logic [63:0] state_lo = '0;
	logic [63:0] key_hi = '0;
	logic [63:0] key_lo = '0;
	logic        final_round = 1'b0;
	logic        done;
	logic [63:0] result_hi;
	logic [63:0] result_lo;

	round_item_t rounds_to_send[$];
	round_out_t  ciphertext_due[$];
	int          idle_left = 0;
	int          rounds_sent = 0;
	int          last_rounds_sent = 0;
	int          drains = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycles = 0;

	aes_cipher_round u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.state_hi   (state_hi),
		.state_lo   (state_lo),
		.key_hi     (key_hi),
		.key_lo     (key_lo),
		.final_round(final_round),
		.done       (done),
		.result_hi  (result_hi),
		.result_lo  (result_lo)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] gf_times2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (acr_pkg::GF_POLY & {8{v[7]}});
	endfunction

	// SubBytes, ShiftRows, MixColumns unless last, AddRoundKey
	function automatic round_out_t aes_round(input logic [63:0] s_hi, input logic [63:0] s_lo,
			input logic [63:0] k_hi, input logic [63:0] k_lo, input logic last);
		logic [7:0] sb [16];
		logic [7:0] kb [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		round_out_t r;
		for (int i = 0; i < 8; i++) begin
			sb[i]     = s_hi[63 - 8 * i -: 8];
			sb[i + 8] = s_lo[63 - 8 * i -: 8];
			kb[i]     = k_hi[63 - 8 * i -: 8];
			kb[i + 8] = k_lo[63 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++)
			for (int row = 0; row < 4; row++)
				t[row + 4 * c] = acr_pkg::SBOX_TAB[sb[row + 4 * ((c + row) % 4)]];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				t[4 * c]     = gf_times2(a0) ^ gf_times2(a1) ^ a1 ^ a2 ^ a3;
				t[4 * c + 1] = a0 ^ gf_times2(a1) ^ gf_times2(a2) ^ a2 ^ a3;
				t[4 * c + 2] = a0 ^ a1 ^ gf_times2(a2) ^ gf_times2(a3) ^ a3;
				t[4 * c + 3] = gf_times2(a0) ^ a0 ^ a1 ^ a2 ^ gf_times2(a3);
			end
		end
		for (int i = 0; i < 8; i++) begin
			r.hi[63 - 8 * i -: 8] = t[i] ^ kb[i];
			r.lo[63 - 8 * i -: 8] = t[i + 8] ^ kb[i + 8];
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int rand_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_round(input logic [63:0] s_hi, input logic [63:0] s_lo,
			input logic [63:0] k_hi, input logic [63:0] k_lo, input logic last,
			input int gap, input bit drain);
		round_item_t it;
		it.st_hi = s_hi;
		it.st_lo = s_lo;
		it.rk_hi = k_hi;
		it.rk_lo = k_lo;
		it.last = last;
		it.gap_after = gap;
		it.drain_first = drain;
		rounds_to_send.push_back(it);
	endtask

	// driver: present items, hold while busy, idle with noise on the payload
	always @(posedge clk) begin
		round_item_t it;
		logic        present;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			present = start && busy;
			if (start && !busy) begin
				ciphertext_due.push_back(aes_round(state_hi, state_lo, key_hi, key_lo,
					final_round));
				rounds_sent++;
				if (final_round)
					last_rounds_sent++;
			end
			if (!present) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (rounds_to_send.size() != 0 &&
						!(rounds_to_send[0].drain_first && ciphertext_due.size() != 0)) begin
					it = rounds_to_send.pop_front();
					if (it.drain_first)
						drains++;
					idle_left = it.gap_after;
					present = 1'b1;
				end
			end
			if (present && !(start && busy)) begin
				state_hi <= it.st_hi;
				state_lo <= it.st_lo;
				key_hi <= it.rk_hi;
				key_lo <= it.rk_lo;
				final_round <= it.last;
			end else if (!present) begin
				state_hi <= rand64();
				state_lo <= rand64();
				key_hi <= rand64();
				key_lo <= rand64();
				final_round <= 1'($urandom_range(0, 1));
			end
			start <= present;
		end
	end

	// monitor: match each strobed result against the oldest predicted round
	always @(posedge clk) begin
		round_out_t want;
		if (arst_n && done) begin
			results_seen++;
			if (ciphertext_due.size() == 0) begin
				$error("result with no round pending: hi %h lo %h", result_hi, result_lo);
				mismatches++;
			end else begin
				want = ciphertext_due.pop_front();
				if (result_hi !== want.hi) begin
					$error("result_hi expected %h actual %h", want.hi, result_hi);
					mismatches++;
				end
				if (result_lo !== want.lo) begin
					$error("result_lo expected %h actual %h", want.lo, result_lo);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d rounds still due", cycles,
				ciphertext_due.size());
			$display("aes_cipher_round test failed");
			$finish;
		end
	end

	initial begin
		// extremes, FIPS-197 round one, byte patterns
		queue_round('0, '0, '0, '0, 1'b0, 0, 1'b0);
		queue_round('0, '0, '0, '0, 1'b1, 0, 1'b0);
		queue_round('1, '1, '1, '1, 1'b0, 0, 1'b0);
		queue_round('1, '1, '1, '1, 1'b1, 1, 1'b0);
		queue_round('0, '0, '1, '1, 1'b0, 0, 1'b0);
		queue_round('1, '1, '0, '0, 1'b1, 0, 1'b0);
		queue_round(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
			64'ha0fafe1788542cb1, 64'h23a339392a6c7605, 1'b0, 2, 1'b0);
		queue_round(64'h193de3bea0f4e22b, 64'h9ac68d2ae9f84808,
			64'ha0fafe1788542cb1, 64'h23a339392a6c7605, 1'b1, 0, 1'b0);
		queue_round(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
			64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 0, 1'b1);
		queue_round(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h0f0e0d0c0b0a0908, 64'h0706050403020100, 1'b0, 0, 1'b0);
		queue_round(64'hf0e0d0c0b0a09080, 64'h7060504030201000,
			64'h8080808080808080, 64'h0101010101010101, 1'b1, 0, 1'b0);
		queue_round(64'h8000000000000000, 64'h0000000000000001, '0, '0, 1'b0, 5, 1'b0);
		queue_round(64'h00000000000000ff, 64'hff00000000000000,
			64'hdeadbeefcafef00d, 64'h0123456789abcdef, 1'b0, 0, 1'b1);
		for (int i = 0; i < RANDOM_ROUNDS; i++)
			queue_round(rand64(), rand64(), rand64(), rand64(), $urandom_range(0, 3) == 0,
				(i % 200 < 40) ? 0 : rand_gap(), $urandom_range(0, 99) == 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (rounds_to_send.size() != 0 || start || ciphertext_due.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (ciphertext_due.size() != 0) begin
			$error("%0d rounds never produced a result", ciphertext_due.size());
			mismatches++;
		end
		$display("%0d rounds sent (%0d final rounds), %0d results checked, %0d full drains",
			rounds_sent, last_rounds_sent, results_seen, drains);
		$display("%0d mismatches in %0d cycles", mismatches, cycles);
		if (mismatches == 0)
			$display("aes_cipher_round test passed");
		else
			$display("aes_cipher_round test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/acr_pkg.sv
rtl/acr_sub_shift.sv
rtl/acr_mix_key.sv
rtl/aes_cipher_round.sv
bench/aes_cipher_round_tb.sv
